// ===== rtl/core/fptw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptw_pkg
// Shared types, constants and codes of the four-level page table walker.
// ----------------------------------------------------------------------------
package fptw_pkg;

    // Entry and address layout
    localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam int          IDX_W      = 9;
    localparam int          OFFSET_W   = 12;

    // Register reset values
    localparam logic [63:0] LOAD_BASE_RST  = 64'h0000_0000_04A0_0000;
    localparam logic [63:0] DIRECT_MAP_RST = 64'hFFFF_8880_0000_0000;
    localparam logic [63:0] KERNEL_MAP_RST = 64'hFFFF_FFFF_8000_0000;

    // Configuration port: three 64-bit registers at 8-byte spacing
    localparam int          APB_AW = 5;
    localparam int          APB_DW = 64;
    localparam logic [1:0]  REG_LOAD_BASE  = 2'd0;
    localparam logic [1:0]  REG_DIRECT_MAP = 2'd1;
    localparam logic [1:0]  REG_KERNEL_MAP = 2'd2;

    // Item codes
    localparam logic        OP_START  = 1'b0;
    localparam logic        OP_RESP   = 1'b1;
    localparam logic        KIND_READ = 1'b0;
    localparam logic        KIND_DONE = 1'b1;

    // Walk levels
    localparam logic [1:0]  LVL_ROOT = 2'd0;
    localparam logic [1:0]  LVL_LEAF = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [63:0] vaddr;
        logic [63:0] root_table_virtual;
        logic [63:0] read_data;
        logic        read_ok;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [63:0] read_address;
        logic [63:0] phys_addr;
        logic        walk_error;
    } t_out_item;

    // 9-bit table index of a virtual address for one level (root first)
    function automatic logic [IDX_W-1:0] level_index(input logic [63:0] va,
                                                     input logic [1:0]  lv);
        logic [IDX_W-1:0] idx;
        case (lv)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/core/four_level_page_table_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Translates kernel virtual addresses by walking a four-level page table.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel. tuser[0] is the opcode: a start item
//   carries vaddr and the root table's kernel virtual address, a response
//   item carries the table entry read from memory and tuser[1] = read_ok.
//   Results leave on the m_axis channel. tuser[0] is the kind: a read request
//   carries the physical entry address in tdata[63:0], a finished walk
//   carries the physical address in tdata[127:64] and tuser[1] = walk_error.
//   A walk is one start item followed by four responses; every start and
//   every response during a walk yields exactly one result, a response with
//   no walk in progress yields none. A start during a walk abandons it.
//   A taken item is held in the input register, then moves on to the
//   result register; one item per cycle is taken while the result register
//   is free or draining, the rate being set by the pass between the two.
//   Reset (synchronous, active low) empties both registers, ends any walk and
//   loads the register reset values. When the receiver stalls, the result is
//   held and the input register still takes one more item before tready
//   drops. The APB port writes the load base, direct_map_base and
//   kernel_map_base at byte addresses 0, 8 and 16; write them only while the
//   block is idle.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
    import fptw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input item channel
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // tdata: vaddr[63:0], root_table_virtual[127:64], read_data[191:128]
    input  logic [191:0]       i_s_axis_tdata,
    // tuser: opcode[0], read_ok[1]
    input  logic [1:0]         i_s_axis_tuser,
    // Result channel
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // tdata: read_address[63:0], phys_addr[127:64]
    output logic [127:0]       o_m_axis_tdata,
    // tuser: kind[0], walk_error[1]
    output logic [1:0]         o_m_axis_tuser,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    // Configuration registers
    logic [63:0] r_load_base;
    logic [63:0] r_direct_map;
    logic [63:0] r_kernel_map;

    // Input register and result register
    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    // Walk state
    logic        r_busy;
    logic [1:0]  r_level;
    logic [63:0] r_saved_vaddr;

    logic        n_busy;
    logic [1:0]  n_level;
    logic [63:0] n_saved_vaddr;
    logic        n_emit;
    t_out_item   n_out;

    logic        advance;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic [63:0] root_off;
    logic [63:0] root_phys;
    logic [1:0]  next_level;
    logic [63:0] frame;

    // Move the input item on when the result register is free or draining
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    always_comb begin
        unique case (cfg_idx)
            REG_LOAD_BASE:  prdata = r_load_base;
            REG_DIRECT_MAP: prdata = r_direct_map;
            REG_KERNEL_MAP: prdata = r_kernel_map;
            default:        prdata = '0;
        endcase
    end

    // Root conversion: kernel-image map when the root lies at or above its
    // nonzero base (the wrapped difference is then smaller), else the direct map.
    assign root_off   = r_in.root_table_virtual - r_kernel_map;
    assign root_phys  = (r_in.root_table_virtual > root_off)
                        ? root_off + r_load_base
                        : r_in.root_table_virtual - r_direct_map;
    assign next_level = r_level + 2'd1;
    assign frame      = r_in.read_data & FRAME_MASK;

    always_comb begin
        n_busy        = r_busy;
        n_level       = r_level;
        n_saved_vaddr = r_saved_vaddr;
        n_emit        = 1'b0;
        n_out         = '0;
        if (r_in.opcode == OP_START) begin
            // Start a walk, abandoning any in progress
            n_busy             = 1'b1;
            n_level            = LVL_ROOT;
            n_saved_vaddr      = r_in.vaddr;
            n_emit             = 1'b1;
            n_out.kind         = KIND_READ;
            n_out.read_address = root_phys
                                 + {52'd0, level_index(r_in.vaddr, LVL_ROOT), 3'b000};
        end else if (r_busy) begin
            n_emit = 1'b1;
            if (!r_in.read_ok) begin
                // Failed read ends the walk with an error
                n_busy           = 1'b0;
                n_level          = LVL_ROOT;
                n_out.kind       = KIND_DONE;
                n_out.walk_error = 1'b1;
            end else if (r_level != LVL_LEAF) begin
                // Frame bits are clear below bit 12, so the index ORs in
                n_level            = next_level;
                n_out.kind         = KIND_READ;
                n_out.read_address = frame
                    | {52'd0, level_index(r_saved_vaddr, next_level), 3'b000};
            end else begin
                n_busy          = 1'b0;
                n_level         = LVL_ROOT;
                n_out.kind      = KIND_DONE;
                n_out.phys_addr = frame | {52'd0, r_saved_vaddr[OFFSET_W-1:0]};
            end
        end
    end

    // Control state, walk state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_busy        <= 1'b0;
            r_level       <= LVL_ROOT;
            r_saved_vaddr <= '0;
            r_load_base   <= LOAD_BASE_RST;
            r_direct_map  <= DIRECT_MAP_RST;
            r_kernel_map  <= KERNEL_MAP_RST;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid   <= n_emit;
                r_busy        <= n_busy;
                r_level       <= n_level;
                r_saved_vaddr <= n_saved_vaddr;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_LOAD_BASE:  r_load_base  <= pwdata;
                    REG_DIRECT_MAP: r_direct_map <= pwdata;
                    REG_KERNEL_MAP: r_kernel_map <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.opcode             <= i_s_axis_tuser[0];
            r_in.read_ok            <= i_s_axis_tuser[1];
            r_in.vaddr              <= i_s_axis_tdata[63:0];
            r_in.root_table_virtual <= i_s_axis_tdata[127:64];
            r_in.read_data          <= i_s_axis_tdata[191:128];
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.phys_addr, r_out.read_address};
    assign o_m_axis_tuser  = {r_out.walk_error, r_out.kind};

endmodule

// ===== rtl/core/fptw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptw_checker
// Port-level checks on the result channel of the page table walker.
// ----------------------------------------------------------------------------
module fptw_checker
    import fptw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,
    input  logic [1:0]   i_m_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

    // Drop the result channel after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // Read requests carry no translation and no error
    a_req_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser[0] == KIND_READ) |->
            !i_m_tuser[1] && (i_m_tdata[127:64] == 64'd0))
        else $error("read request carries result fields");

    // An error ends the walk with all addresses zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1] |->
            (i_m_tuser[0] == KIND_DONE) && (i_m_tdata == 128'd0))
        else $error("failed walk reports an address");

endmodule

bind four_level_page_table_walker fptw_checker u_fptw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

// ===== bench/tb_four_level_page_table_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker
// Self-checking bench for the four-level page table walker. A directed table
// of walks covers the root conversion rules, wraparound, failed reads at the
// root and the leaf, restarts and responses with no walk in progress. Random
// walks follow under several register settings. Every result item is
// compared in order with a pinned row result or an in-bench walker model.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker;
    import fptw_pkg::*;

    localparam int RX_HOLD_CYCLES = 80;    // long receiver stall
    localparam int STALL_LIMIT    = 1000;  // cycles with no item moving
    localparam int SETTLE_CYCLES  = 6;     // covers both pipeline registers
    localparam int WALK_ITEMS     = 80;    // start and in-walk response items per traffic run

    typedef struct {
        t_in_item  it;
        bit        pin;
        t_out_item want;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    // tdata: vaddr[63:0], root_table_virtual[127:64], read_data[191:128]
    logic [191:0]       i_s_axis_tdata;
    // tuser: opcode[0], read_ok[1]
    logic [1:0]         i_s_axis_tuser;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    // tdata: read_address[63:0], phys_addr[127:64]
    logic [127:0]       o_m_axis_tdata;
    // tuser: kind[0], walk_error[1]
    logic [1:0]         o_m_axis_tuser;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Typed expectation that travels with a directed item
    bit                 row_pinned;
    t_out_item          row_result;

    // Walker model state and its copy of the registers
    bit                 walk_busy;
    logic [1:0]         walk_level;
    logic [63:0]        walk_vaddr;
    logic [63:0]        cfg_load_base;
    logic [63:0]        cfg_direct_map;
    logic [63:0]        cfg_kernel_map;

    t_out_item          pending_results[$];
    t_dir_row           dir_rows[$];
    int                 mismatches;
    int                 quiet_cycles;
    int                 holds_asked;
    int                 holds_served;
    bit                 calm;

    four_level_page_table_walker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item start_item(input logic [63:0] va, input logic [63:0] root);
        t_in_item it;
        it = '0;
        it.opcode = OP_START;
        it.vaddr = va;
        it.root_table_virtual = root;
        return it;
    endfunction

    function automatic t_in_item resp_item(input logic [63:0] entry, input logic ok);
        t_in_item it;
        it = '0;
        it.opcode = OP_RESP;
        it.read_data = entry;
        it.read_ok = ok;
        return it;
    endfunction

    function automatic t_out_item read_req(input logic [63:0] addr);
        t_out_item r;
        r = '0;
        r.kind = KIND_READ;
        r.read_address = addr;
        return r;
    endfunction

    function automatic t_out_item walk_done(input logic [63:0] pa, input logic err);
        t_out_item r;
        r = '0;
        r.kind = KIND_DONE;
        r.phys_addr = pa;
        r.walk_error = err;
        return r;
    endfunction

    // Byte offset of a level's 8-byte entry inside its table
    function automatic logic [63:0] entry_offset(input logic [63:0] va, input logic [1:0] lv);
        return ((va >> (39 - 9 * int'(lv))) & 64'h1FF) << 3;
    endfunction

    // Advance the walker model by one item; returns 1 when a result is due
    function automatic bit walk_step(input t_in_item it, output t_out_item res);
        logic [63:0] base;
        res = '0;
        if (it.opcode == OP_START) begin
            walk_busy = 1'b1;
            walk_level = LVL_ROOT;
            walk_vaddr = it.vaddr;
            // Kernel image map when the root lies at or above a nonzero base,
            // direct map otherwise; every sum wraps
            base = it.root_table_virtual - cfg_kernel_map;
            if (it.root_table_virtual > base)
                base = base + cfg_load_base;
            else
                base = base + (cfg_kernel_map - cfg_direct_map);
            res = read_req(base + entry_offset(it.vaddr, LVL_ROOT));
            return 1'b1;
        end
        // Drop responses with no walk in progress
        if (!walk_busy)
            return 1'b0;
        if (!it.read_ok) begin
            walk_busy = 1'b0;
            walk_level = LVL_ROOT;
            res = walk_done(64'd0, 1'b1);
            return 1'b1;
        end
        if (walk_level != LVL_LEAF) begin
            walk_level = walk_level + 2'd1;
            res = read_req((it.read_data & FRAME_MASK) + entry_offset(walk_vaddr, walk_level));
            return 1'b1;
        end
        walk_busy = 1'b0;
        walk_level = LVL_ROOT;
        res = walk_done((it.read_data & FRAME_MASK) | {52'd0, walk_vaddr[OFFSET_W-1:0]}, 1'b0);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // Offer one item, with a random gap before it unless the run is calm,
    // and return at the edge where it is taken. tvalid stays high on return.
    task automatic offer_item(input t_in_item it, input bit pin, input t_out_item want);
        if (!calm && $urandom_range(0, 99) < 15) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {it.read_data, it.root_table_virtual, it.vaddr};
        i_s_axis_tuser <= {it.read_ok, it.opcode};
        row_pinned <= pin;
        row_result <= want;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    // Drop tvalid and let every expected result drain, then let the walker
    // settle on any trailing item that produced no result
    task automatic drain_walker();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register (setup, access), then read it back the same way
    task automatic program_reg(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_LOAD_BASE:  cfg_load_base = value;
            REG_DIRECT_MAP: cfg_direct_map = value;
            REG_KERNEL_MAP: cfg_kernel_map = value;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value)
            report_mismatch($sformatf("register %0d readback: expected %h, got %h",
                                      idx, value, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed walks with random content; some stray responses,
    // failed reads and walks cut short by a fresh start
    task automatic run_walk_traffic(input int count);
        int        sent;
        int        step;
        logic      ok;
        logic [63:0] root;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 8) begin
                offer_item(resp_item(rnd64(), 1'($urandom_range(0, 1))), 1'b0, '0);
                continue;
            end
            case ($urandom_range(0, 3))
                0:       root = cfg_kernel_map + (rnd64() & 64'h3FFF_FFFF);
                1:       root = cfg_direct_map + (rnd64() & 64'h3FFF_FFFF_FFFF);
                2:       root = rnd64();
                default: root = $urandom_range(0, 1) ? '1 : '0;
            endcase
            offer_item(start_item(rnd64(), root), 1'b0, '0);
            sent++;
            for (step = 0; step < 4; step++) begin
                if ($urandom_range(0, 99) < 6)
                    break;
                ok = ($urandom_range(0, 99) >= 6);
                offer_item(resp_item(rnd64(), ok), 1'b0, '0);
                sent++;
                if (!ok)
                    break;
            end
        end
    endtask

    // Predict on every accepted input item, check every accepted result item,
    // and watch for a stretch in which nothing moves
    always @(posedge i_clk) begin
        t_in_item  in_it;
        t_out_item want;
        t_out_item got;
        bit        due;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                in_it.opcode = i_s_axis_tuser[0];
                in_it.read_ok = i_s_axis_tuser[1];
                in_it.vaddr = i_s_axis_tdata[63:0];
                in_it.root_table_virtual = i_s_axis_tdata[127:64];
                in_it.read_data = i_s_axis_tdata[191:128];
                due = walk_step(in_it, want);
                if (due)
                    pending_results.push_back(row_pinned ? row_result : want);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind = o_m_axis_tuser[0];
                got.walk_error = o_m_axis_tuser[1];
                got.read_address = o_m_axis_tdata[63:0];
                got.phys_addr = o_m_axis_tdata[127:64];
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind=%0b ra=%h pa=%h err=%0b",
                                              got.kind, got.read_address, got.phys_addr,
                                              got.walk_error));
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.read_address !== want.read_address ||
                        got.phys_addr !== want.phys_addr || got.walk_error !== want.walk_error)
                        report_mismatch($sformatf(
                            "result: expected kind=%0b ra=%h pa=%h err=%0b, %s%0b %h %h %0b",
                            want.kind, want.read_address, want.phys_addr, want.walk_error,
                            "got ", got.kind, got.read_address, got.phys_addr,
                            got.walk_error));
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: random backpressure, a long hold when asked, none when calm
    initial begin
        i_m_axis_tready = 1'b0;
        holds_served = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                i_m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
            end
        end
    end

    initial begin
        int          ph;
        int          k;
        logic [63:0] pb;
        logic [63:0] dm;
        logic [63:0] km;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        row_pinned = 1'b0;
        row_result = '0;
        mismatches = 0;
        quiet_cycles = 0;
        holds_asked = 0;
        calm = 1'b0;
        walk_busy = 1'b0;
        walk_level = LVL_ROOT;
        walk_vaddr = '0;
        cfg_load_base = LOAD_BASE_RST;
        cfg_direct_map = DIRECT_MAP_RST;
        cfg_kernel_map = KERNEL_MAP_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walks under the reset register values
        // Response with no walk in progress: dropped
        dir_rows.push_back('{resp_item('1, 1'b1), 1'b0, '0});
        // Root at the kernel image base, all-zero entries and all-ones entries
        dir_rows.push_back('{start_item('0, KERNEL_MAP_RST), 1'b1,
                             read_req(64'h0000_0000_04A0_0000)});
        dir_rows.push_back('{resp_item('1, 1'b1), 1'b1, read_req(FRAME_MASK)});
        dir_rows.push_back('{resp_item('0, 1'b1), 1'b1, read_req('0)});
        dir_rows.push_back('{resp_item('1, 1'b1), 1'b1, read_req(FRAME_MASK)});
        dir_rows.push_back('{resp_item('1, 1'b1), 1'b1, walk_done(FRAME_MASK, 1'b0)});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        // Root at the direct map base, all-ones address: top index 0x1FF
        dir_rows.push_back('{start_item('1, DIRECT_MAP_RST), 1'b1, read_req(64'hFF8)});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        // Failed read in the middle of a walk
        dir_rows.push_back('{resp_item(rnd64(), 1'b0), 1'b1, walk_done('0, 1'b1)});
        // Start abandoned by a second start, then a full walk with offset 0xFFF
        dir_rows.push_back('{start_item(rnd64(), rnd64()), 1'b0, '0});
        dir_rows.push_back('{start_item(64'hFFF, rnd64()), 1'b0, '0});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        dir_rows.push_back('{resp_item('0, 1'b1), 1'b1, walk_done(64'hFFF, 1'b0)});
        // Root zero falls to the direct map rule and wraps
        dir_rows.push_back('{start_item('0, '0), 1'b1, read_req(64'h0000_7780_0000_0000)});
        // Failed read of the root entry
        dir_rows.push_back('{resp_item('1, 1'b0), 1'b1, walk_done('0, 1'b1)});
        // All-ones root: kernel image rule
        dir_rows.push_back('{start_item('0, '1), 1'b1, read_req(64'h0000_0000_849F_FFFF)});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        dir_rows.push_back('{resp_item(rnd64(), 1'b1), 1'b0, '0});
        // Failed read of the leaf entry
        dir_rows.push_back('{resp_item(rnd64(), 1'b0), 1'b1, walk_done('0, 1'b1)});
        dir_rows.push_back('{resp_item(rnd64(), 1'b0), 1'b0, '0});
        // Root one below the kernel image base: direct map rule
        dir_rows.push_back('{start_item('1, KERNEL_MAP_RST - 64'd1), 1'b0, '0});
        foreach (dir_rows[k])
            offer_item(dir_rows[k].it, dir_rows[k].pin, dir_rows[k].want);

        run_walk_traffic(WALK_ITEMS);

        // Register phases: extremes, the opposite extremes with no idling,
        // random values, and back to the reset values
        for (ph = 1; ph <= 4; ph++) begin
            drain_walker();
            case (ph)
                1: begin pb = '1; dm = '0; km = '0; end
                2: begin pb = '0; dm = '1; km = '1; end
                3: begin pb = rnd64(); dm = rnd64(); km = rnd64(); end
                default: begin pb = LOAD_BASE_RST; dm = DIRECT_MAP_RST; km = KERNEL_MAP_RST; end
            endcase
            program_reg(REG_LOAD_BASE, pb);
            program_reg(REG_DIRECT_MAP, dm);
            program_reg(REG_KERNEL_MAP, km);
            calm = (ph == 2);
            if (ph == 1) begin
                // Hold the result side off while starts keep coming
                holds_asked++;
                for (k = 0; k < 10; k++)
                    offer_item(start_item(rnd64(), rnd64()), 1'b0, '0);
            end
            run_walk_traffic(WALK_ITEMS);
        end

        drain_walker();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fptw_pkg.sv
rtl/core/four_level_page_table_walker.sv
rtl/core/fptw_checker.sv
bench/tb_four_level_page_table_walker.sv
